### hdl/tbpc_pkg.sv
`default_nettype none

package tbpc_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned StepWidth = 16;
   localparam int unsigned ActionWidth = 3;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [TimeWidth-1:0] DebounceTimeReset = TimeWidth'(20 * 1000);
   localparam logic [TimeWidth-1:0] LongPressReset = TimeWidth'(1000000);
   localparam logic [TimeWidth-1:0] BothPressReset = TimeWidth'(500000);

   localparam logic [CsrIndexWidth-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BOTH_PRESS = 2'd2;

   localparam logic [ActionWidth-1:0] ACT_NONE = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_SHORT = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_LONG = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_LONG_REL = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_BOTH = 3'd4;

   // Debounced view of one button after the current tick.
   typedef struct packed {
      logic pressed;
      logic over_long;
      logic over_both;
   } btn_status_type;

endpackage

`default_nettype wire

### hdl/tbpc_debounce.sv
`default_nettype none

module tbpc_debounce
   import tbpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic [StepWidth-1:0] step_us,
   input  wire logic                 raw,
   input  wire logic [TimeWidth-1:0] debounce_time_us,
   input  wire logic [TimeWidth-1:0] long_press_threshold_us,
   input  wire logic [TimeWidth-1:0] both_press_threshold_us,
   output btn_status_type            status
);

   logic                 level_ff;
   logic                 level_in;
   logic [TimeWidth-1:0] steady_ff;
   logic [TimeWidth-1:0] steady_in;
   logic [TimeWidth:0]   sum;
   logic [TimeWidth-1:0] sat;
   logic                 resample;
   logic                 clear;

   always_comb begin
      sum = {1'b0, steady_ff} + {{(TimeWidth + 1 - StepWidth){1'b0}}, step_us};
      sat = sum[TimeWidth] ? {TimeWidth{1'b1}} : sum[TimeWidth-1:0];
      resample = (sat >= debounce_time_us);
      clear = resample && (level_ff != raw);
      level_in = resample ? raw : level_ff;
      steady_in = clear ? '0 : sat;
      // A cleared counter only passes a threshold of zero.
      status.pressed = level_in;
      status.over_long = clear ? (long_press_threshold_us == '0)
                               : (sat >= long_press_threshold_us);
      status.over_both = clear ? (both_press_threshold_us == '0)
                               : (sat >= both_press_threshold_us);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 1'b0;
         steady_ff <= '0;
      end else if (enable) begin
         level_ff <= level_in;
         steady_ff <= steady_in;
      end
   end

endmodule

`default_nettype wire

### hdl/two_button_press_classifier_top.sv
// Two-button press classifier with debouncing.
// Input channel (req_): one beat per tick carries the microseconds since the
// previous tick and the raw left and right levels. Each tick yields exactly
// one result beat on the rsp_ channel: an action type and its direction.
// Configuration (csr_): index 0 debounce time, 1 long-press threshold,
// 2 both-press threshold; other indexes are ignored. csr_ready is always high.
// The result of a beat accepted at one edge is registered and valid right after
// that edge. Throughput is one tick per cycle while the receiver does not stall,
// set by the single result register; the debounce counters and the press state
// update in the same cycle as the accepting edge.
// When the receiver stalls, the result register holds its beat and req_ready
// falls, so no tick is taken until the held result is gone; a new tick is
// accepted in the same cycle in which the held result is taken.
// Reset (synchronous) empties the result register, returns the configuration
// to its defaults, clears the debounced levels and counters and puts the
// press state machine into neutral.
`default_nettype none

module two_button_press_classifier_top
   import tbpc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [StepWidth-1:0]     req_step_us,
   input  wire logic                     req_raw_left,
   input  wire logic                     req_raw_right,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [ActionWidth-1:0]        rsp_action_type,
   output logic                          rsp_action_right,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [TimeWidth-1:0]     csr_data
);

   typedef enum logic [6:0] {
      ST_NEUTRAL = 7'b0000001,
      ST_L_UNDER = 7'b0000010,
      ST_L_OVER  = 7'b0000100,
      ST_R_UNDER = 7'b0001000,
      ST_R_OVER  = 7'b0010000,
      ST_BOTH    = 7'b0100000,
      ST_WAIT    = 7'b1000000
   } press_state_type;

   press_state_type        state_ff;
   press_state_type        state_in;
   logic [TimeWidth-1:0]   debounce_ff;
   logic [TimeWidth-1:0]   long_ff;
   logic [TimeWidth-1:0]   both_ff;
   logic                   rsp_valid_ff;
   logic [ActionWidth-1:0] type_ff;
   logic [ActionWidth-1:0] type_in;
   logic                   right_ff;
   logic                   right_in;
   logic                   req_fire;
   btn_status_type         left;
   btn_status_type         right;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_action_type = type_ff;
   assign rsp_action_right = right_ff;

   tbpc_debounce u_left (
      .clock                   (clock),
      .reset                   (reset),
      .enable                  (req_fire),
      .step_us                 (req_step_us),
      .raw                     (req_raw_left),
      .debounce_time_us        (debounce_ff),
      .long_press_threshold_us (long_ff),
      .both_press_threshold_us (both_ff),
      .status                  (left)
   );

   tbpc_debounce u_right (
      .clock                   (clock),
      .reset                   (reset),
      .enable                  (req_fire),
      .step_us                 (req_step_us),
      .raw                     (req_raw_right),
      .debounce_time_us        (debounce_ff),
      .long_press_threshold_us (long_ff),
      .both_press_threshold_us (both_ff),
      .status                  (right)
   );

   always_comb begin
      state_in = state_ff;
      type_in = ACT_NONE;
      right_in = 1'b0;
      unique case (state_ff)
         ST_NEUTRAL: begin
            if (left.pressed && right.pressed) begin
               state_in = ST_BOTH;
            end else if (left.pressed) begin
               state_in = ST_L_UNDER;
            end else if (right.pressed) begin
               state_in = ST_R_UNDER;
            end
         end
         ST_L_UNDER: begin
            if (!left.pressed) begin
               type_in = ACT_SHORT;
               state_in = ST_WAIT;
            end else if (right.pressed) begin
               state_in = ST_BOTH;
            end else if (left.over_long) begin
               type_in = ACT_LONG;
               state_in = ST_L_OVER;
            end
         end
         ST_L_OVER: begin
            if (!left.pressed) begin
               type_in = ACT_LONG_REL;
               state_in = ST_WAIT;
            end
         end
         ST_R_UNDER: begin
            if (!right.pressed) begin
               type_in = ACT_SHORT;
               right_in = 1'b1;
               state_in = ST_WAIT;
            end else if (left.pressed) begin
               state_in = ST_BOTH;
            end else if (right.over_long) begin
               type_in = ACT_LONG;
               right_in = 1'b1;
               state_in = ST_R_OVER;
            end
         end
         ST_R_OVER: begin
            if (!right.pressed) begin
               type_in = ACT_LONG_REL;
               right_in = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_BOTH: begin
            if (!left.pressed || !right.pressed) begin
               state_in = ST_WAIT;
            end else if (left.over_both && right.over_both) begin
               type_in = ACT_BOTH;
               state_in = ST_WAIT;
            end
         end
         default: begin
            // Wait for neutral; an illegal code recovers the same way.
            state_in = (!left.pressed && !right.pressed) ? ST_NEUTRAL : ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_NEUTRAL;
         rsp_valid_ff <= 1'b0;
         debounce_ff <= DebounceTimeReset;
         long_ff <= LongPressReset;
         both_ff <= BothPressReset;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEBOUNCE) begin
               debounce_ff <= csr_data;
            end
            if (csr_index == CSR_LONG_PRESS) begin
               long_ff <= csr_data;
            end
            if (csr_index == CSR_BOTH_PRESS) begin
               both_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= type_in;
         right_ff <= right_in;
      end
   end

endmodule

`default_nettype wire

### hdl/tbpc_checker.sv
`default_nettype none

module tbpc_checker
   import tbpc_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [ActionWidth-1:0] rsp_action_type,
   input wire logic                   rsp_action_right
);

   // A held result must not be lost while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Every accepted tick produces a result in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick gave no result");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_action_type == ACT_NONE || rsp_action_type == ACT_SHORT ||
                     rsp_action_type == ACT_LONG || rsp_action_type == ACT_LONG_REL ||
                     rsp_action_type == ACT_BOTH))
      else $error("action type out of range");

   // No action and both pressed carry no direction.
   a_no_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action_type == ACT_NONE || rsp_action_type == ACT_BOTH)
         |-> !rsp_action_right)
      else $error("direction set on an undirected action");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind two_button_press_classifier_top tbpc_checker u_tbpc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_action_type  (rsp_action_type),
   .rsp_action_right (rsp_action_right)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import tbpc_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned WatchdogLimit = 3000;
   localparam int unsigned HoldTicks = 20;

   typedef enum logic [2:0] {
      PS_NEUTRAL,
      PS_LEFT_SHORT,
      PS_LEFT_LONG,
      PS_RIGHT_SHORT,
      PS_RIGHT_LONG,
      PS_BOTH,
      PS_WAIT
   } press_state_type;

   typedef struct packed {
      logic [ActionWidth-1:0] kind;
      logic                   right;
   } action_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [StepWidth-1:0]     req_step_us = '0;
   logic                     req_raw_left = 1'b0;
   logic                     req_raw_right = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ActionWidth-1:0]   rsp_action_type;
   logic                     rsp_action_right;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [TimeWidth-1:0]     csr_data = '0;

   two_button_press_classifier_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_step_us      (req_step_us),
      .req_raw_left     (req_raw_left),
      .req_raw_right    (req_raw_right),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_action_type  (rsp_action_type),
      .rsp_action_right (rsp_action_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted block state: timing registers, debounced buttons and press state.
   logic [TimeWidth-1:0] debounce_us = DebounceTimeReset;
   logic [TimeWidth-1:0] long_press_us = LongPressReset;
   logic [TimeWidth-1:0] both_press_us = BothPressReset;
   logic                 left_down = 1'b0;
   logic                 right_down = 1'b0;
   logic [TimeWidth-1:0] left_held_us = '0;
   logic [TimeWidth-1:0] right_held_us = '0;
   press_state_type      press_state = PS_NEUTRAL;

   action_rec_type pending_actions[$];
   int      errors = 0;
   int      ticks_driven = 0;
   int      ticks_checked = 0;
   int      settings_used = 1;
   int      action_count[0:4] = '{default: 0};
   int      burst_left = 0;
   bit      sender_idles = 1'b1;
   int      quiet_cycles = 0;

   task automatic settle_button(inout logic down, inout logic [TimeWidth-1:0] held_us,
                                input logic [StepWidth-1:0] step_us, input logic raw);
      logic [TimeWidth:0] sum;
      sum = {1'b0, held_us} + (TimeWidth+1)'(step_us);
      held_us = sum[TimeWidth] ? '1 : sum[TimeWidth-1:0];
      if (held_us >= debounce_us) begin
         if (down != raw) held_us = '0;
         down = raw;
      end
   endtask

   task automatic classify_tick(input logic [StepWidth-1:0] step_us, input logic raw_left,
                                input logic raw_right, output action_rec_type act);
      act.kind = ACT_NONE;
      act.right = 1'b0;
      settle_button(left_down, left_held_us, step_us, raw_left);
      settle_button(right_down, right_held_us, step_us, raw_right);
      case (press_state)
         PS_NEUTRAL: begin
            if (left_down && right_down) press_state = PS_BOTH;
            else if (left_down) press_state = PS_LEFT_SHORT;
            else if (right_down) press_state = PS_RIGHT_SHORT;
         end
         PS_LEFT_SHORT: begin
            if (left_down) begin
               if (right_down) begin
                  press_state = PS_BOTH;
               end else if (left_held_us >= long_press_us) begin
                  act.kind = ACT_LONG;
                  press_state = PS_LEFT_LONG;
               end
            end else begin
               act.kind = ACT_SHORT;
               press_state = PS_WAIT;
            end
         end
         PS_LEFT_LONG: begin
            if (!left_down) begin
               act.kind = ACT_LONG_REL;
               press_state = PS_WAIT;
            end
         end
         PS_RIGHT_SHORT: begin
            if (right_down) begin
               if (left_down) begin
                  press_state = PS_BOTH;
               end else if (right_held_us >= long_press_us) begin
                  act.kind = ACT_LONG;
                  act.right = 1'b1;
                  press_state = PS_RIGHT_LONG;
               end
            end else begin
               act.kind = ACT_SHORT;
               act.right = 1'b1;
               press_state = PS_WAIT;
            end
         end
         PS_RIGHT_LONG: begin
            if (!right_down) begin
               act.kind = ACT_LONG_REL;
               act.right = 1'b1;
               press_state = PS_WAIT;
            end
         end
         PS_BOTH: begin
            if (!left_down || !right_down) begin
               press_state = PS_WAIT;
            end else if (left_held_us >= both_press_us && right_held_us >= both_press_us) begin
               act.kind = ACT_BOTH;
               press_state = PS_WAIT;
            end
         end
         default: begin
            if (!left_down && !right_down) press_state = PS_NEUTRAL;
         end
      endcase
   endtask

   // Register writes, result checks and tick predictions all follow the beats
   // seen at each rising edge.
   always @(posedge clock) begin : beat_monitor
      action_rec_type seen;
      action_rec_type want;
      action_rec_type predicted;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE: debounce_us = csr_data;
               CSR_LONG_PRESS: long_press_us = csr_data;
               CSR_BOTH_PRESS: both_press_us = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen.kind = rsp_action_type;
            seen.right = rsp_action_right;
            if (pending_actions.size() == 0) begin
               $error("result beat with no tick outstanding: action_type %0d, action_right %0d",
                      seen.kind, seen.right);
               errors++;
            end else begin
               want = pending_actions.pop_front();
               ticks_checked++;
               if (want.kind <= ACT_BOTH) action_count[want.kind]++;
               if (seen.kind !== want.kind) begin
                  $error("action_type mismatch: expected %0d, actual %0d", want.kind, seen.kind);
                  errors++;
               end
               if (seen.right !== want.right) begin
                  $error("action_right mismatch: expected %0d, actual %0d",
                         want.right, seen.right);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            classify_tick(req_step_us, req_raw_left, req_raw_right, predicted);
            pending_actions.push_back(predicted);
         end
      end
   end

   // Receiver stall pattern: rsp_ready follows one of four modes, picked anew at random.
   int unsigned stall_cycle = 0;
   int unsigned stall_mode = 0;
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_cycle % 32) >= 20;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input logic [StepWidth-1:0] step_us, input logic raw_left,
                            input logic raw_right);
      int gap;
      if (burst_left == 0) begin
         gap = (sender_idles && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_step_us <= step_us;
      req_raw_left <= raw_left;
      req_raw_right <= raw_right;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      ticks_driven++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CsrIndexWidth-1:0] idx, input logic [TimeWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_timing(input logic [TimeWidth-1:0] debounce_value,
                                 input logic [TimeWidth-1:0] long_value,
                                 input logic [TimeWidth-1:0] both_value);
      drain();
      csr_beat(CSR_DEBOUNCE, debounce_value);
      csr_beat(CSR_LONG_PRESS, long_value);
      csr_beat(CSR_BOTH_PRESS, both_value);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [StepWidth-1:0] pick_step(input int unsigned step_hi);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return StepWidth'($urandom);
         default: return StepWidth'($urandom_range(0, step_hi));
      endcase
   endfunction

   // Press gestures with random timing: solo presses, both together, a second
   // button joining late, one of two dropping early, and plain chatter.
   task automatic run_gestures(input int n_ticks, input int unsigned step_hi,
                               input int hold_max);
      int start;
      int hold;
      int rest;
      logic stays_left;
      start = ticks_driven;
      while (ticks_driven - start < n_ticks) begin
         hold = $urandom_range(1, hold_max);
         rest = $urandom_range(1, 4);
         stays_left = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3))
               send_tick(StepWidth'($urandom_range(0, step_hi / 4)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
         end
         case ($urandom_range(0, 5))
            0: repeat (hold) send_tick(pick_step(step_hi), 1'b1, 1'b0);
            1: repeat (hold) send_tick(pick_step(step_hi), 1'b0, 1'b1);
            2: repeat (hold) send_tick(pick_step(step_hi), 1'b1, 1'b1);
            3: begin
               repeat (hold / 2 + 1) send_tick(pick_step(step_hi), stays_left, !stays_left);
               repeat (hold) send_tick(pick_step(step_hi), 1'b1, 1'b1);
            end
            4: begin
               repeat (hold) send_tick(pick_step(step_hi), 1'b1, 1'b1);
               repeat (hold / 2 + 1) send_tick(pick_step(step_hi), stays_left, !stays_left);
            end
            default: begin
               repeat (hold)
                  send_tick(pick_step(step_hi), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
            end
         endcase
         repeat (rest) send_tick(pick_step(step_hi), 1'b0, 1'b0);
      end
   endtask

   task automatic test_reset_defaults();
      run_gestures(120, 65535, 40);
   endtask

   // With zero debounce every tick is sampled, so each action lands on the
   // tick that causes it.
   task automatic test_directed_actions();
      program_timing('0, 1000, 500);
      repeat (2) send_tick('0, 1'b0, 1'b0);
      send_tick('1, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b0);
      send_tick(999, 1'b1, 1'b0);
      send_tick(1, 1'b1, 1'b0);
      send_tick(7, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b1);
      send_tick(500, 1'b0, 1'b1);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b0);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b0, 1'b1);
      send_tick('1, 1'b0, 1'b1);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b1);
      send_tick(499, 1'b1, 1'b1);
      send_tick(1, 1'b1, 1'b1);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b1);
      send_tick('0, 1'b1, 1'b0);
      send_tick('0, 1'b0, 1'b0);
      send_tick('0, 1'b1, 1'b0);
      send_tick(3, 1'b1, 1'b1);
   endtask

   task automatic test_zero_thresholds();
      program_timing('0, '0, '0);
      run_gestures(150, 200, 6);
   endtask

   task automatic test_ignored_index();
      drain();
      csr_beat(CSR_SPARE, '0);
      csr_valid <= 1'b0;
      run_gestures(150, 200, 6);
   endtask

   task automatic test_short_timing();
      program_timing(100, 3000, 1500);
      sender_idles = 1'b0;
      run_gestures(150, 400, 16);
      sender_idles = 1'b1;
   endtask

   task automatic test_long_timing();
      program_timing(5000, 200000, 100000);
      run_gestures(150, 30000, 14);
   endtask

   task automatic test_both_unreachable();
      program_timing(1, 1, '1);
      run_gestures(150, 50, 10);
   endtask

   task automatic test_random_timing();
      program_timing($urandom_range(0, 2000), $urandom_range(0, 40000),
                     $urandom_range(0, 40000));
      run_gestures(150, 5000, 16);
   endtask

   // Maximal debounce holds off sampling, so pressed levels on the raw inputs
   // never reach the press state machine while the counters keep growing.
   task automatic test_max_debounce();
      program_timing('0, 1000, 500);
      repeat (3) send_tick('0, 1'b0, 1'b0);
      program_timing('1, '1, '1);
      sender_idles = 1'b0;
      repeat (HoldTicks) send_tick('1, 1'b1, 1'b0);
      repeat (4) send_tick('1, 1'b1, 1'b1);
      repeat (3) send_tick('0, 1'b0, 1'b0);
      sender_idles = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_actions();
      test_zero_thresholds();
      test_ignored_index();
      test_short_timing();
      test_long_timing();
      test_both_unreachable();
      test_max_debounce();
      test_random_timing();
      drain();
      if (pending_actions.size() != 0) begin
         $error("%0d expected results never arrived", pending_actions.size());
         errors++;
      end
      $display("Checked %0d ticks over %0d timing settings, maximal debounce included.",
               ticks_checked, settings_used);
      $display("Actions seen: %0d short, %0d long, %0d long-release, %0d both-pressed.",
               action_count[ACT_SHORT], action_count[ACT_LONG], action_count[ACT_LONG_REL],
               action_count[ACT_BOTH]);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
